// File: sv/oriented_box_set_distance_core_defines.svh
// Assertion macros used by the checker of the oriented box distance core.
`ifndef ORIENTED_BOX_SET_DISTANCE_CORE_DEFINES_SVH
`define ORIENTED_BOX_SET_DISTANCE_CORE_DEFINES_SVH

// Check that a condition in one cycle implies another in the next cycle.
`define OBSD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Check that a condition implies another in the same cycle.
`define OBSD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`endif

// File: sv/obsd_pkg.sv
// Command codes and shared constants of the oriented box distance core.
`timescale 1ns / 1ps
package obsd_pkg;

  localparam logic [1:0] CMD_CENTER = 2'd0;
  localparam logic [1:0] CMD_HALF   = 2'd1;
  localparam logic [1:0] CMD_ROT    = 2'd2;
  localparam logic [1:0] CMD_QUERY  = 2'd3;

  localparam int S_TDATA_W = 136;
  localparam int M_TDATA_W = 32;

  // Table depth; box_index is 6 bits wide
  localparam int MAX_BOXES = 64;

endpackage

// File: sv/oriented_box_set_distance_core.sv
// Signed distance from a query point to a table of oriented boxes.
//
//  channel | dir | handshake           | content
//  s_*     | in  | s_tvalid / s_tready | tuser: command; tdata: box_index, comp_x..comp_w
//  m_*     | out | m_tvalid / m_tready | tdata: distance
//  cfg_*   | in  | cfg_valid/cfg_ready | cfg_data: box_count
//
// A load word leaves s_tready high. A query keeps s_tready low until its result
// word is loaded, including the output hand-off. With n = min(box_count,
// MAX_BOXES), each of boxes 1 to n - 2 passes the shared multiplier sequence,
// the bit-serial square root and a minimum update; no box is evaluated when
// n < 3. A result held on m_tdata does not block new words.
// Reset clears control state; table contents stay undefined.
`timescale 1ns / 1ps
module oriented_box_set_distance_core
  import obsd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  // [5:0] box_index, [37:6] comp_x, [69:38] comp_y, [101:70] comp_z,
  // [133:102] comp_w, [135:134] zero
  input  logic [S_TDATA_W-1:0] s_tdata,
  // [1:0] command
  input  logic [1:0]           s_tuser,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  // [31:0] distance
  output logic [M_TDATA_W-1:0] m_tdata,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [6:0]           cfg_data
);

  localparam int IW = $clog2(MAX_BOXES);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_CALC = 3'd1;
  localparam logic [2:0] ST_ROOT = 3'd2;
  localparam logic [2:0] ST_ACC  = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;

  function automatic logic signed [33:0] sat33(input logic signed [36:0] x);
    if (x < -37'sh1_0000_0000) return -34'sh1_0000_0000;
    if (x > 37'sh0_FFFF_FFFF)  return 34'sh0_FFFF_FFFF;
    return 34'(x);
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [38:0] x);
    if (x < -39'sh8000_0000) return 32'sh8000_0000;
    if (x > 39'sh7FFF_FFFF)  return 32'sh7FFF_FFFF;
    return 32'(x);
  endfunction

  // Box table
  logic [95:0]  cen_mem [MAX_BOXES];
  logic [95:0]  hs_mem  [MAX_BOXES];
  logic [127:0] rot_mem [MAX_BOXES];
  logic [95:0]  cen_q, hs_q;
  logic [127:0] rot_q;

  logic [2:0]  state;
  logic [4:0]  step;
  logic [4:0]  k;
  logic [6:0]  nbox, ibox;
  logic [6:0]  count;

  logic signed [31:0] p [3];
  logic signed [32:0] d [3];
  logic signed [33:0] uv [3];
  logic signed [33:0] uuv [3];
  logic signed [37:0] r [3];
  logic signed [31:0] q [3];
  logic signed [31:0] mx;
  logic signed [35:0] tmp;
  logic signed [35:0] mrnd;
  logic [63:0]        mraw;
  logic [63:0]        sum, rem, res;
  logic signed [35:0] best;

  logic s_acc, is_query;
  logic [6:0] nbox_in;

  assign s_tready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign s_acc     = s_tvalid && s_tready;
  assign is_query  = (s_tuser == CMD_QUERY);
  assign nbox_in   = (32'(count) < MAX_BOXES) ? count : 7'(MAX_BOXES);

  // Table writes and registered reads
  always_ff @(posedge clk) begin
    if (s_acc && !is_query && (32'(s_tdata[5:0]) < MAX_BOXES)) begin
      unique case (s_tuser)
        CMD_CENTER: cen_mem[IW'(s_tdata[5:0])] <= s_tdata[101:6];
        CMD_HALF:   hs_mem[IW'(s_tdata[5:0])]  <= s_tdata[101:6];
        default:    rot_mem[IW'(s_tdata[5:0])] <= s_tdata[133:6];
      endcase
    end
    if (state == ST_CALC && step == 5'd0) begin
      cen_q <= cen_mem[IW'(ibox)];
      hs_q  <= hs_mem[IW'(ibox)];
      rot_q <= rot_mem[IW'(ibox)];
    end
  end

  logic signed [31:0] u [3];
  logic signed [31:0] w;
  logic signed [31:0] h [3];
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      u[j] = signed'(rot_q[32*j +: 32]);
      h[j] = signed'(hs_q[32*j +: 32]);
    end
    w = signed'(rot_q[127:96]);
  end

  // Shared multiplier: operand select by step
  logic signed [31:0] ma_s;
  logic signed [33:0] mb_s;
  always_comb begin
    ma_s = '0;
    mb_s = '0;
    case (step)
      5'd2:  begin ma_s = u[1]; mb_s = 34'(d[2]); end
      5'd3:  begin ma_s = u[2]; mb_s = 34'(d[1]); end
      5'd4:  begin ma_s = u[2]; mb_s = 34'(d[0]); end
      5'd5:  begin ma_s = u[0]; mb_s = 34'(d[2]); end
      5'd6:  begin ma_s = u[0]; mb_s = 34'(d[1]); end
      5'd7:  begin ma_s = u[1]; mb_s = 34'(d[0]); end
      5'd9:  begin ma_s = u[1]; mb_s = uv[2]; end
      5'd10: begin ma_s = u[2]; mb_s = uv[1]; end
      5'd11: begin ma_s = u[2]; mb_s = uv[0]; end
      5'd12: begin ma_s = u[0]; mb_s = uv[2]; end
      5'd13: begin ma_s = u[0]; mb_s = uv[1]; end
      5'd14: begin ma_s = u[1]; mb_s = uv[0]; end
      5'd15: begin ma_s = w;    mb_s = uv[0]; end
      5'd16: begin ma_s = w;    mb_s = uv[1]; end
      5'd17: begin ma_s = w;    mb_s = uv[2]; end
      5'd20: begin ma_s = q[0]; mb_s = 34'(q[0]); end
      5'd21: begin ma_s = q[1]; mb_s = 34'(q[1]); end
      5'd22: begin ma_s = q[2]; mb_s = 34'(q[2]); end
      default: ;
    endcase
  end

  logic signed [32:0] a_wide;
  logic signed [34:0] b_wide;
  logic [31:0]        ma;
  logic [32:0]        mb;
  logic [64:0]        mag;
  logic [34:0]        rnd;
  logic               mneg;
  always_comb begin
    a_wide = 33'(ma_s);
    b_wide = 35'(mb_s);
    ma     = a_wide[32] ? 32'(-a_wide) : 32'(a_wide);
    mb     = b_wide[34] ? 33'(-b_wide) : 33'(b_wide);
    mneg   = ma_s[31] ^ mb_s[33];
    mag    = 65'(ma) * 65'(mb);
    rnd    = 35'((mag + 65'(32'h2000_0000)) >> 30);
  end

  // Per-component helpers for the consume side
  logic signed [33:0] wuv;
  logic signed [36:0] cdiff;
  logic signed [37:0] r_new;
  logic [1:0]         rsel;
  always_comb begin
    wuv   = sat33(37'(mrnd));
    cdiff = 37'(tmp) - 37'(mrnd);
    rsel  = (step == 5'd16) ? 2'd0 : ((step == 5'd17) ? 2'd1 : 2'd2);
    r_new = 38'(d[rsel]) + ((38'(uuv[rsel]) - 38'(wuv)) <<< 1);
  end

  logic signed [31:0] q_new [3];
  logic signed [37:0] rabs;
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      rabs     = r[j][37] ? -r[j] : r[j];
      q_new[j] = sat32(39'(rabs) - (39'(h[j]) <<< 1));
    end
  end

  // Bit-serial root step
  logic [5:0]  sh;
  logic [63:0] bitv, trial;
  always_comb begin
    sh    = 6'(7'd62 - 7'({k, 1'b0}));
    bitv  = 64'd1 << sh;
    trial = res + bitv;
  end

  logic signed [35:0] box_dist;
  assign box_dist = 36'(signed'({2'b00, res[33:0]})) + (mx[31] ? 36'(mx) : 36'sd0);

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
      count    <= '0;
      step     <= '0;
      k        <= '0;
    end else begin
      if (cfg_valid && cfg_ready) count <= cfg_data;
      if (m_tready && state != ST_OUT) m_tvalid <= 1'b0;
      mrnd <= mneg ? -36'(rnd) : 36'(rnd);
      mraw <= mag[63:0];
      unique case (state)
        ST_IDLE: begin
          if (s_acc && is_query) begin
            p[0] <= signed'(s_tdata[37:6]);
            p[1] <= signed'(s_tdata[69:38]);
            p[2] <= signed'(s_tdata[101:70]);
            nbox <= nbox_in;
            best <= 36'sh0_7FFF_FFFF;
            ibox <= 7'd1;
            step <= '0;
            state <= (nbox_in < 7'd3) ? ST_OUT : ST_CALC;
          end
        end
        ST_CALC: begin
          step <= step + 5'd1;
          case (step) inside
            5'd1: for (int j = 0; j < 3; j++)
                    d[j] <= 33'(p[j]) - 33'(signed'(cen_q[32*j +: 32]));
            5'd3, 5'd5, 5'd7, 5'd10, 5'd12, 5'd14: tmp <= mrnd;
            5'd4:  uv[0]  <= sat33(cdiff);
            5'd6:  uv[1]  <= sat33(cdiff);
            5'd8:  uv[2]  <= sat33(cdiff);
            5'd11: uuv[0] <= sat33(cdiff);
            5'd13: uuv[1] <= sat33(cdiff);
            5'd15: uuv[2] <= sat33(cdiff);
            5'd16, 5'd17, 5'd18: r[rsel] <= r_new;
            5'd19: for (int j = 0; j < 3; j++) q[j] <= q_new[j];
            5'd20: begin
              mx <= (q[0] > q[1]) ? ((q[0] > q[2]) ? q[0] : q[2])
                                  : ((q[1] > q[2]) ? q[1] : q[2]);
            end
            5'd21: sum <= q[0][31] ? 64'd0 : mraw;
            5'd22: sum <= sum + (q[1][31] ? 64'd0 : mraw);
            5'd23: begin
              sum   <= sum + (q[2][31] ? 64'd0 : mraw);
              rem   <= sum + (q[2][31] ? 64'd0 : mraw);
              res   <= '0;
              k     <= '0;
              state <= ST_ROOT;
            end
            default: ;
          endcase
        end
        ST_ROOT: begin
          if (rem >= trial) begin
            rem <= rem - trial;
            res <= (res >> 1) + bitv;
          end else begin
            res <= res >> 1;
          end
          k <= k + 5'd1;
          if (k == 5'd31) state <= ST_ACC;
        end
        ST_ACC: begin
          if (box_dist < best) best <= box_dist;
          step <= '0;
          if (8'(ibox) + 8'd2 < 8'(nbox)) begin
            ibox  <= ibox + 7'd1;
            state <= ST_CALC;
          end else begin
            state <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tdata  <= sat32(39'(best));
            m_tvalid <= 1'b1;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// File: sv/obsd_checker.sv
// Port-level checks of the oriented box distance core and their binding.
`timescale 1ns / 1ps
`include "oriented_box_set_distance_core_defines.svh"
module obsd_checker
  import obsd_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 s_tvalid,
  input logic                 s_tready,
  input logic [1:0]           s_tuser,
  input logic                 m_tvalid,
  input logic                 m_tready,
  input logic [M_TDATA_W-1:0] m_tdata
);

  // Hold a stalled result word
  `OBSD_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result dropped while stalled")
  // Go busy after a query word
  `OBSD_ASSERT_NEXT(a_query_busy, s_tvalid && s_tready && (s_tuser == CMD_QUERY), !s_tready, "ready after query")
  // Stay ready after a load word
  `OBSD_ASSERT_NEXT(a_load_ready, s_tvalid && s_tready && (s_tuser != CMD_QUERY), s_tready, "load stalled input")

endmodule

bind oriented_box_set_distance_core obsd_checker u_obsd_checker (.*);

// File: tb/sv/tb_oriented_box_set_distance_core.sv
// Self-checking testbench for the oriented box set distance core.
`timescale 1ns / 1ps
module tb_oriented_box_set_distance_core;
  import obsd_pkg::*;

  localparam int NBOX = MAX_BOXES;
  typedef longint vec3_t [3];

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata = '0;
  logic [1:0]           s_tuser = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [6:0]           cfg_data = '0;

  // Predictor copy of the box table and the count register
  logic [31:0] box_center [NBOX][3];
  logic [31:0] box_half   [NBOX][3];
  logic [31:0] box_quat   [NBOX][4];
  int unsigned box_count_reg = 0;

  logic [31:0] expected_distances [$];
  int unsigned errors = 0;
  bit          calm = 1'b0;
  int unsigned stall_order = 0;
  int unsigned stall_seen = 0;
  int unsigned stall_left = 0;

  oriented_box_set_distance_core dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    #100_000_000;
    $display("oriented_box_set_distance_core regression: fail");
    $finish;
  end

  // ---------------- prediction ----------------
  function automatic longint clamp(longint x, longint lo, longint hi);
    return x < lo ? lo : (x > hi ? hi : x);
  endfunction

  function automatic longint clamp33(longint x);
    return clamp(x, -64'sh1_0000_0000, 64'sh0_FFFF_FFFF);
  endfunction

  // Q2.30 times Q16.16, rounded half away from zero
  function automatic longint mul_q30(longint a, longint b);
    bit neg;
    longint unsigned ma, mb, p;
    neg = (a < 0) != (b < 0);
    ma = a < 0 ? longint'(-a) : a;
    mb = b < 0 ? longint'(-b) : b;
    p = (ma * mb + 64'd536870912) >> 30;
    return neg ? -longint'(p) : longint'(p);
  endfunction

  function automatic longint unsigned floor_sqrt(longint unsigned n);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic vec3_t cross_clamped(vec3_t u, vec3_t v);
    vec3_t r;
    r[0] = clamp33(mul_q30(u[1], v[2]) - mul_q30(u[2], v[1]));
    r[1] = clamp33(mul_q30(u[2], v[0]) - mul_q30(u[0], v[2]));
    r[2] = clamp33(mul_q30(u[0], v[1]) - mul_q30(u[1], v[0]));
    return r;
  endfunction

  function automatic longint box_signed_distance(int b, vec3_t pt);
    vec3_t d, u, uv, uuv;
    longint w, mx, r, a, q;
    longint unsigned sum;
    w = longint'($signed(box_quat[b][3]));
    mx = -64'sh7FFF_FFFF_FFFF_FFFF;
    sum = 0;
    for (int k = 0; k < 3; k++) begin
      d[k] = pt[k] - longint'($signed(box_center[b][k]));
      u[k] = longint'($signed(box_quat[b][k]));
    end
    uv = cross_clamped(u, d);
    uuv = cross_clamped(u, uv);
    for (int k = 0; k < 3; k++) begin
      r = d[k] + 2 * (uuv[k] - clamp33(mul_q30(w, uv[k])));
      a = r < 0 ? -r : r;
      q = clamp(a - 2 * longint'($signed(box_half[b][k])), -64'sh8000_0000, 64'sh7FFF_FFFF);
      if (q > mx) mx = q;
      if (q > 0) sum += longint'(q) * longint'(q);
    end
    return longint'(floor_sqrt(sum)) + (mx < 0 ? mx : 0);
  endfunction

  function automatic logic [31:0] min_distance_predict(logic [31:0] x, logic [31:0] y,
                                                       logic [31:0] z);
    vec3_t pt;
    longint best, box_dist;
    int unsigned n;
    pt[0] = longint'($signed(x));
    pt[1] = longint'($signed(y));
    pt[2] = longint'($signed(z));
    best = 64'sh7FFF_FFFF;
    n = box_count_reg < NBOX ? box_count_reg : NBOX;
    for (int i = 1; i + 1 < n; i++) begin
      box_dist = box_signed_distance(i, pt);
      if (box_dist < best) best = box_dist;
    end
    best = clamp(best, -64'sh8000_0000, 64'sh7FFF_FFFF);
    return best[31:0];
  endfunction

  // ---------------- drivers ----------------
  task automatic report_mismatch(string what);
    $display("MISMATCH @%0t: %s", $realtime, what);
    errors++;
  endtask

  // Send one word, hold it until accepted, then update the predictor
  task automatic send_word(logic [1:0] cmd, logic [5:0] idx, logic [31:0] x,
                           logic [31:0] y, logic [31:0] z, logic [31:0] w);
    if (!calm && $urandom_range(99) < 14) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= cmd;
    s_tdata <= {2'b00, w, z, y, x, idx};
    do @(posedge clk); while (!s_tready);
    case (cmd)
      CMD_CENTER: begin
        box_center[idx][0] = x; box_center[idx][1] = y; box_center[idx][2] = z;
      end
      CMD_HALF: begin
        box_half[idx][0] = x; box_half[idx][1] = y; box_half[idx][2] = z;
      end
      CMD_ROT: begin
        box_quat[idx][0] = x; box_quat[idx][1] = y; box_quat[idx][2] = z;
        box_quat[idx][3] = w;
      end
      default: expected_distances = {expected_distances, min_distance_predict(x, y, z)};
    endcase
  endtask

  // Write box_count once the core has drained
  task automatic write_box_count(logic [6:0] value);
    s_tvalid <= 1'b0;
    do @(posedge clk); while (expected_distances.size() != 0);
    repeat (10) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    box_count_reg = 32'(value);
  endtask

  function automatic logic [31:0] rnd_coord();
    case ($urandom_range(9)) inside
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0;
      3: return 32'hFFFF_FFFF;
      4, 5, 6: return $urandom_range(0, 32'h0040_0000) - 32'h0020_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] rnd_quat();
    case ($urandom_range(7))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return $urandom;
      default: return $urandom_range(0, 32'h8000_0000) - 32'h4000_0000;
    endcase
  endfunction

  // Receiver: random ready, with a long hold-off on request
  always @(posedge clk) begin
    if (stall_order != stall_seen) begin
      stall_seen <= stall_order;
      stall_left <= 300;
      m_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= calm || ($urandom_range(99) >= 14);
    end
  end

  // Check each result word against the oldest expectation
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (expected_distances.size() == 0) begin
        report_mismatch($sformatf("unexpected distance %h", m_tdata));
      end else begin
        if (m_tdata !== expected_distances[0])
          report_mismatch($sformatf("distance %h, want %h", m_tdata, expected_distances[0]));
        void'(expected_distances.pop_front());
      end
    end
  end

  // ---------------- tests ----------------
  // Write every entry so no query reads an unwritten box
  task automatic test_table_load();
    for (int i = 0; i < NBOX; i++) begin
      send_word(CMD_CENTER, 6'(i), $urandom_range(0, 32'h0040_0000) - 32'h0020_0000,
                $urandom_range(0, 32'h0040_0000) - 32'h0020_0000,
                $urandom_range(0, 32'h0040_0000) - 32'h0020_0000, $urandom);
      send_word(CMD_HALF, 6'(i), $urandom_range(0, 32'h0008_0000),
                $urandom_range(0, 32'h0008_0000), $urandom_range(0, 32'h0008_0000), $urandom);
      send_word(CMD_ROT, 6'(i), rnd_quat(), rnd_quat(), rnd_quat(), rnd_quat());
    end
  endtask

  task automatic test_directed();
    write_box_count(7'd0);
    send_word(CMD_QUERY, 6'd0, 32'h0, 32'h0, 32'h0, 32'h0);
    write_box_count(7'd2);
    send_word(CMD_QUERY, 6'd63, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'hFFFF_FFFF);
    write_box_count(7'd3);
    // identity rotation and extreme geometry in box 1
    send_word(CMD_ROT, 6'd1, 32'h0, 32'h0, 32'h0, 32'h4000_0000);
    send_word(CMD_CENTER, 6'd1, 32'h0, 32'h0, 32'h0, 32'h0);
    send_word(CMD_HALF, 6'd1, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'h0);
    send_word(CMD_QUERY, 6'd0, 32'h0, 32'h0, 32'h0, 32'h0);
    send_word(CMD_QUERY, 6'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0);
    send_word(CMD_QUERY, 6'd0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h0);
    send_word(CMD_HALF, 6'd1, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0);
    send_word(CMD_CENTER, 6'd1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0);
    send_word(CMD_QUERY, 6'd0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0);
    // saturating rotation terms
    send_word(CMD_ROT, 6'd1, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
    send_word(CMD_QUERY, 6'd0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0);
    send_word(CMD_ROT, 6'd1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_word(CMD_QUERY, 6'd0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h0);
    write_box_count(7'd64);
    send_word(CMD_QUERY, 6'd0, 32'h0001_0000, 32'hFFFF_0000, 32'h0, 32'h0);
    write_box_count(7'd127);
    send_word(CMD_QUERY, 6'd0, 32'h0, 32'h0002_0000, 32'hFFFE_0000, 32'h0);
  endtask

  task automatic test_output_backpressure();
    write_box_count(7'd3);
    stall_order++;
    for (int i = 0; i < 6; i++)
      send_word(CMD_QUERY, 6'd0, rnd_coord(), rnd_coord(), rnd_coord(), $urandom);
  endtask

  task automatic test_random_phase(logic [6:0] count, int unsigned items, bit no_gaps);
    logic [1:0] cmd;
    write_box_count(count);
    calm = no_gaps;
    for (int i = 0; i < items; i++) begin
      cmd = ($urandom_range(99) < 40) ? CMD_QUERY : 2'($urandom_range(2));
      if (cmd == CMD_ROT)
        send_word(cmd, 6'($urandom_range(63)), rnd_quat(), rnd_quat(), rnd_quat(),
                  rnd_quat());
      else
        send_word(cmd, 6'($urandom_range(63)), rnd_coord(), rnd_coord(), rnd_coord(),
                  $urandom);
    end
    calm = 1'b0;
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_table_load();
    test_directed();
    test_output_backpressure();
    test_random_phase(7'd3, 80, 1'b0);
    test_random_phase(7'd5, 80, 1'b1);
    test_random_phase(7'd8, 80, 1'b0);
    test_random_phase(7'd4, 80, 1'b0);
    test_random_phase(7'd2, 80, 1'b0);
    test_random_phase(7'd1, 80, 1'b0);
    test_random_phase(7'd0, 80, 1'b0);
    test_random_phase(7'd6, 80, 1'b0);
    test_random_phase(7'd64, 12, 1'b0);
    test_random_phase(7'd127, 12, 1'b0);
    test_random_phase(7'd3, 80, 1'b0);
    // drain and let the last load settle
    s_tvalid <= 1'b0;
    do @(posedge clk); while (expected_distances.size() != 0);
    repeat (20) @(posedge clk);
    if (errors == 0)
      $display("oriented_box_set_distance_core regression: pass");
    else
      $display("oriented_box_set_distance_core regression: fail");
    $finish;
  end

endmodule

// File: sim.f
+incdir+sv
sv/obsd_pkg.sv
sv/oriented_box_set_distance_core.sv
sv/obsd_checker.sv
tb/sv/tb_oriented_box_set_distance_core.sv
